// File: hw/rtl/atu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Accelerometer tilt angle unit: shared package
// Widths, fixed-point formats and the CORDIC arctangent table in degrees.
// ----------------------------------------------------------------------------
package atu_pkg;

    // sample and datapath formats
    localparam int SAMPLE_BITS      = 16;
    localparam int ANGLE_ITERATIONS = 16;
    localparam int FRACTION_BITS    = 8;
    localparam int GUARD_BITS       = 31 - SAMPLE_BITS;
    localparam int TABLE_LEN        = 24;
    localparam int CORDIC_ITERS     = (ANGLE_ITERATIONS < TABLE_LEN) ?
                                      ANGLE_ITERATIONS : TABLE_LEN;
    localparam int ANGLE_FRAC       = 24;
    localparam int MID_FRAC         = 16;

    // square, sum and root widths
    localparam int SQ_W    = 2 * SAMPLE_BITS - 1;
    localparam int SUM_W   = 2 * SAMPLE_BITS;
    localparam int RAD_W   = SUM_W + 2 * GUARD_BITS;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 3;

    // CORDIC widths
    localparam int XY_W    = ROOT_W + 3;
    localparam int ANG_W   = ANGLE_FRAC + 8;

    // angle magnitude at MID_FRAC, its squares, output
    localparam int MID_W   = MID_FRAC + 7;
    localparam int PROD_W  = 2 * MID_W;
    localparam int SS_W    = PROD_W + 1;
    localparam int OUT_W   = FRACTION_BITS + 7;
    localparam int RND_SH  = MID_FRAC - FRACTION_BITS;
    localparam int RED_SH  = ANGLE_FRAC - MID_FRAC;
    localparam logic [OUT_W-1:0] TILT_LIMIT = OUT_W'(90 << FRACTION_BITS);

    typedef logic signed [ANG_W-1:0] t_angle;

    // atan(2^-i) in degrees, 24 fraction bits, rounded
    function automatic t_angle atan_deg(input int idx);
        t_angle v;
        case (idx)
            0:       v = ANG_W'(754974720);
            1:       v = ANG_W'(445687602);
            2:       v = ANG_W'(235489088);
            3:       v = ANG_W'(119537938);
            4:       v = ANG_W'(60000934);
            5:       v = ANG_W'(30029717);
            6:       v = ANG_W'(15018523);
            7:       v = ANG_W'(7509720);
            8:       v = ANG_W'(3754917);
            9:       v = ANG_W'(1877466);
            10:      v = ANG_W'(938734);
            11:      v = ANG_W'(469367);
            12:      v = ANG_W'(234684);
            13:      v = ANG_W'(117342);
            14:      v = ANG_W'(58671);
            15:      v = ANG_W'(29335);
            16:      v = ANG_W'(14668);
            17:      v = ANG_W'(7334);
            18:      v = ANG_W'(3667);
            19:      v = ANG_W'(1833);
            20:      v = ANG_W'(917);
            21:      v = ANG_W'(458);
            22:      v = ANG_W'(229);
            23:      v = ANG_W'(115);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/accel_tilt_angle_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Accelerometer tilt angle unit
// Pitch and roll from one 3-axis sample, then tilt = sqrt(pitch^2 + roll^2).
// ----------------------------------------------------------------------------
// Usage:
//   Input word: i_accel_x/y/z, taken at a clock edge with start high and
//   busy low. busy stays low, so a word may be issued every cycle.
//   Result word: o_tilt_degrees (degrees, 8 fraction bits, 0..90), shown
//   for one cycle with o_valid high. The receiver cannot hold it off.
// Pipeline: 3 square/sum stages, a 31-stage root, a 16-stage CORDIC,
//   3 reduce/square/sum stages, a 31-stage root and an output stage.
// Throughput: one word per cycle; every stage is a register with its own
//   valid bit and nothing is shared between words.
// Reset: synchronous, clears all valid bits; words in flight are dropped
//   and no strobe follows until new words are accepted.
// ----------------------------------------------------------------------------
module accel_tilt_angle_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [atu_pkg::SAMPLE_BITS-1:0] i_accel_x,
    input  logic signed [atu_pkg::SAMPLE_BITS-1:0] i_accel_y,
    input  logic signed [atu_pkg::SAMPLE_BITS-1:0] i_accel_z,
    output logic                                   o_valid,
    output logic [atu_pkg::OUT_W-1:0]              o_tilt_degrees
);
    import atu_pkg::*;

    // fully pipelined, never stalls
    assign busy = 1'b0;

    // stage 1: capture sample
    logic                          r_v1;
    logic signed [SAMPLE_BITS-1:0] r_x1, r_y1, r_z1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x1 <= i_accel_x;
        r_y1 <= i_accel_y;
        r_z1 <= i_accel_z;
    end

    // stage 2: squares
    logic                          r_v2;
    logic [SQ_W-1:0]               r_xx, r_yy, r_zz;
    logic signed [SAMPLE_BITS-1:0] r_x2, r_y2;
    logic signed [SUM_W-1:0]       w_xx, w_yy, w_zz;

    assign w_xx = r_x1 * r_x1;
    assign w_yy = r_y1 * r_y1;
    assign w_zz = r_z1 * r_z1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xx <= w_xx[SQ_W-1:0];
        r_yy <= w_yy[SQ_W-1:0];
        r_zz <= w_zz[SQ_W-1:0];
        r_x2 <= r_x1;
        r_y2 <= r_y1;
    end

    // stage 3: radial sums
    logic                          r_v3;
    logic [SUM_W-1:0]              r_sxz, r_syz;
    logic signed [SAMPLE_BITS-1:0] r_x3, r_y3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sxz <= {1'b0, r_xx} + {1'b0, r_zz};
        r_syz <= {1'b0, r_yy} + {1'b0, r_zz};
        r_x3  <= r_x2;
        r_y3  <= r_y2;
    end

    // radial roots, sample words delayed alongside
    logic              w_rv_xz, w_rv_yz;
    logic [ROOT_W-1:0] w_rxz, w_ryz;

    atu_isqrt u_root_xz (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_v3),
        .i_radicand ({r_sxz, {(2*GUARD_BITS){1'b0}}}),
        .o_valid    (w_rv_xz),
        .o_root     (w_rxz)
    );

    atu_isqrt u_root_yz (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_v3),
        .i_radicand ({r_syz, {(2*GUARD_BITS){1'b0}}}),
        .o_valid    (w_rv_yz),
        .o_root     (w_ryz)
    );

    logic signed [SAMPLE_BITS-1:0] r_dx [0:ROOT_W-1];
    logic signed [SAMPLE_BITS-1:0] r_dy [0:ROOT_W-1];

    always_ff @(posedge i_clk) begin
        r_dx[0] <= r_x3;
        r_dy[0] <= r_y3;
        for (int i = 1; i < ROOT_W; i++) begin
            r_dx[i] <= r_dx[i-1];
            r_dy[i] <= r_dy[i-1];
        end
    end

    // pitch and roll
    logic   w_pv, w_rv;
    t_angle w_pitch, w_roll;

    atu_cordic u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_rv_xz),
        .i_a     (w_rxz),
        .i_b     (r_dy[ROOT_W-1]),
        .o_valid (w_pv),
        .o_angle (w_pitch)
    );

    atu_cordic u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_rv_yz),
        .i_a     (w_ryz),
        .i_b     (r_dx[ROOT_W-1]),
        .o_valid (w_rv),
        .o_angle (w_roll)
    );

    // magnitudes rounded half up to MID_FRAC
    logic             r_vr;
    logic [MID_W-1:0] r_pm, r_rm;
    logic [ANG_W-1:0] w_pabs, w_rabs, w_pmr, w_rmr;

    assign w_pabs = w_pitch[ANG_W-1] ? ANG_W'(-w_pitch) : ANG_W'(w_pitch);
    assign w_rabs = w_roll[ANG_W-1]  ? ANG_W'(-w_roll)  : ANG_W'(w_roll);
    assign w_pmr  = (w_pabs + ANG_W'(1 << (RED_SH - 1))) >> RED_SH;
    assign w_rmr  = (w_rabs + ANG_W'(1 << (RED_SH - 1))) >> RED_SH;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vr <= 1'b0;
        end else begin
            r_vr <= w_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pm <= w_pmr[MID_W-1:0];
        r_rm <= w_rmr[MID_W-1:0];
    end

    // squares of the angles
    logic              r_vm;
    logic [PROD_W-1:0] r_pp, r_rr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
        end else begin
            r_vm <= r_vr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pp <= r_pm * r_pm;
        r_rr <= r_rm * r_rm;
    end

    // sum of squares
    logic            r_vs;
    logic [SS_W-1:0] r_ss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vs <= 1'b0;
        end else begin
            r_vs <= r_vm;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ss <= {1'b0, r_pp} + {1'b0, r_rr};
    end

    // tilt root
    logic              w_tv;
    logic [ROOT_W-1:0] w_tilt;

    atu_isqrt u_root_tilt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_vs),
        .i_radicand ({{(RAD_W-SS_W){1'b0}}, r_ss}),
        .o_valid    (w_tv),
        .o_root     (w_tilt)
    );

    // round to output fraction bits and saturate at 90 degrees
    logic                r_valid;
    logic [OUT_W-1:0]    r_tilt;
    logic [ROOT_W-1:0]   w_rnd;
    logic [OUT_W-1:0]    n_tilt;

    always_comb begin
        w_rnd = (w_tilt + ROOT_W'(1 << (RND_SH - 1))) >> RND_SH;
        if (w_rnd > ROOT_W'(TILT_LIMIT)) begin
            n_tilt = TILT_LIMIT;
        end else begin
            n_tilt = w_rnd[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_tv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tilt <= n_tilt;
    end

    assign o_valid        = r_valid;
    assign o_tilt_degrees = r_tilt;

    // checks
    a_tilt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_tilt_degrees <= TILT_LIMIT))
        else $error("tilt above 90 degrees");

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pv == w_rv) && (w_rv_xz == w_rv_yz))
        else $error("pitch and roll lanes out of step");

    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tv |=> o_valid)
        else $error("root result lost at output stage");

    a_root_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vs |-> ##ROOT_W w_tv)
        else $error("tilt root word lost");

endmodule

// File: hw/rtl/atu_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined integer square root
// floor(sqrt(radicand)), one result bit per register stage, ROOT_W stages.
// ----------------------------------------------------------------------------
module atu_isqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [atu_pkg::RAD_W-1:0]  i_radicand,
    output logic                       o_valid,
    output logic [atu_pkg::ROOT_W-1:0] o_root
);
    import atu_pkg::*;

    logic              r_v    [0:ROOT_W-1];
    logic [RAD_W-1:0]  r_n    [0:ROOT_W-1];
    logic [REM_W-1:0]  r_rem  [0:ROOT_W-1];
    logic [ROOT_W-1:0] r_root [0:ROOT_W-1];

    logic              w_v    [0:ROOT_W];
    logic [RAD_W-1:0]  w_n    [0:ROOT_W];
    logic [REM_W-1:0]  w_rem  [0:ROOT_W];
    logic [ROOT_W-1:0] w_root [0:ROOT_W];

    assign w_v[0]    = i_valid;
    assign w_n[0]    = i_radicand;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++) begin : g_stage
            logic [REM_W-1:0]  n_rem;
            logic [ROOT_W-1:0] n_root;
            logic [REM_W-1:0]  trial_rem;
            logic [REM_W-1:0]  trial;

            // bring down two radicand bits, try subtracting 4q+1
            always_comb begin
                trial_rem = {w_rem[k][REM_W-3:0], w_n[k][RAD_W-1 -: 2]};
                trial     = {1'b0, w_root[k], 2'b01};
                if (trial_rem >= trial) begin
                    n_rem  = trial_rem - trial;
                    n_root = {w_root[k][ROOT_W-2:0], 1'b1};
                end else begin
                    n_rem  = trial_rem;
                    n_root = {w_root[k][ROOT_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else begin
                    r_v[k] <= w_v[k];
                end
            end

            always_ff @(posedge i_clk) begin
                r_n[k]    <= w_n[k] << 2;
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
            end

            assign w_v[k+1]    = r_v[k];
            assign w_n[k+1]    = r_n[k];
            assign w_rem[k+1]  = r_rem[k];
            assign w_root[k+1] = r_root[k];
        end
    endgenerate

    assign o_valid = w_v[ROOT_W];
    assign o_root  = w_root[ROOT_W];

endmodule

// File: hw/rtl/atu_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined vectoring CORDIC
// atan2(b, a) for a >= 0 in degrees, 24 fraction bits, one iteration a stage.
// ----------------------------------------------------------------------------
module atu_cordic (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [atu_pkg::ROOT_W-1:0]      i_a,
    input  logic signed [atu_pkg::SAMPLE_BITS-1:0] i_b,
    output logic                            o_valid,
    output atu_pkg::t_angle                 o_angle
);
    import atu_pkg::*;

    logic                    r_v    [0:CORDIC_ITERS-1];
    logic                    r_zero [0:CORDIC_ITERS-1];
    logic signed [XY_W-1:0]  r_x    [0:CORDIC_ITERS-1];
    logic signed [XY_W-1:0]  r_y    [0:CORDIC_ITERS-1];
    t_angle                  r_ang  [0:CORDIC_ITERS-1];

    logic                    w_v    [0:CORDIC_ITERS];
    logic                    w_zero [0:CORDIC_ITERS];
    logic signed [XY_W-1:0]  w_x    [0:CORDIC_ITERS];
    logic signed [XY_W-1:0]  w_y    [0:CORDIC_ITERS];
    t_angle                  w_ang  [0:CORDIC_ITERS];

    // b scaled by the guard bits; zero vector flagged for atan2(0,0) = 0
    assign w_v[0]    = i_valid;
    assign w_zero[0] = (i_a == '0) && (i_b == '0);
    assign w_x[0]    = $signed({{(XY_W-ROOT_W){1'b0}}, i_a});
    assign w_y[0]    = $signed({{(XY_W-SAMPLE_BITS-GUARD_BITS){i_b[SAMPLE_BITS-1]}},
                                i_b, {GUARD_BITS{1'b0}}});
    assign w_ang[0]  = '0;

    genvar k;
    generate
        for (k = 0; k < CORDIC_ITERS; k++) begin : g_iter
            logic signed [XY_W-1:0] dx;
            logic signed [XY_W-1:0] dy;
            assign dx = w_y[k] >>> k;
            assign dy = w_x[k] >>> k;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else begin
                    r_v[k] <= w_v[k];
                end
            end

            // rotate toward zero, y >= 0 counts as positive
            always_ff @(posedge i_clk) begin
                r_zero[k] <= w_zero[k];
                if (!w_y[k][XY_W-1]) begin
                    r_x[k]   <= w_x[k] + dx;
                    r_y[k]   <= w_y[k] - dy;
                    r_ang[k] <= w_ang[k] + atan_deg(k);
                end else begin
                    r_x[k]   <= w_x[k] - dx;
                    r_y[k]   <= w_y[k] + dy;
                    r_ang[k] <= w_ang[k] - atan_deg(k);
                end
            end

            assign w_v[k+1]    = r_v[k];
            assign w_zero[k+1] = r_zero[k];
            assign w_x[k+1]    = r_x[k];
            assign w_y[k+1]    = r_y[k];
            assign w_ang[k+1]  = r_ang[k];
        end
    endgenerate

    assign o_valid = w_v[CORDIC_ITERS];
    assign o_angle = w_zero[CORDIC_ITERS] ? '0 : w_ang[CORDIC_ITERS];

endmodule
